### hdl/trv_pkg.sv
// ----------------------------------------------------------------------------
// trv_pkg
// shared widths and helpers for the two-ray vertex estimate datapath
// ----------------------------------------------------------------------------
package trv_pkg;

  localparam int POS_W     = 32;
  localparam int DIR_W     = 18;
  localparam int Q_W       = 64;
  localparam int Q_SAT_EXP = 62;

  typedef logic signed [Q_W-1:0] q_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [Q_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > Q_W'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (v < -(Q_W'(64'sh80000000))) begin
      r = 32'sh80000000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/trv_div.sv
// ----------------------------------------------------------------------------
// trv_div
// pipelined restoring divider, one quotient bit per stage, sign applied and
// quotient saturated on the last stage; zero divisor gives zero
// ----------------------------------------------------------------------------
module trv_div #(
  parameter int N = 51,
  parameter int D = 18
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [N-1:0]                  num,
  input  logic [D-1:0]                  den,
  input  logic                          neg,
  output logic signed [trv_pkg::Q_W-1:0] res
);
  import trv_pkg::*;

  localparam int QX = (N > Q_W) ? N : Q_W;

  logic [D-1:0] rem_r [N];
  logic [N-1:0] num_r [N];
  logic [N-1:0] quo_r [N];
  logic [D-1:0] den_r [N];
  logic         neg_r [N];
  logic signed [Q_W-1:0] res_r;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D-1:0] r_in;
    logic [D-1:0] d_in;
    logic [N-1:0] n_in;
    logic [N-1:0] q_in;
    logic         s_in;
    logic [D:0]   trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign d_in = den;
      assign n_in = num;
      assign q_in = '0;
      assign s_in = neg;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign n_in = num_r[k-1];
      assign q_in = quo_r[k-1];
      assign s_in = neg_r[k-1];
    end

    assign trial = {r_in, n_in[N-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? D'(trial - {1'b0, d_in}) : trial[D-1:0];
        num_r[k] <= n_in << 1;
        quo_r[k] <= {q_in[N-2:0], ge};
        den_r[k] <= d_in;
        neg_r[k] <= s_in;
      end
    end
  end

  logic [QX-1:0]  qx;
  logic [Q_W-1:0] qmag;

  always_comb begin
    qx = QX'(quo_r[N-1]);
    if (qx >= (QX'(1) << Q_SAT_EXP)) begin
      qmag = Q_W'(1) << Q_SAT_EXP;
    end else begin
      qmag = qx[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (den_r[N-1] == '0) begin
        res_r <= '0;
      end else if (neg_r[N-1]) begin
        res_r <= -$signed(qmag);
      end else begin
        res_r <= $signed(qmag);
      end
    end
  end

  assign res = res_r;

endmodule

### hdl/trv_delay.sv
// ----------------------------------------------------------------------------
// trv_delay
// side-data delay line with a valid lane, advances with the pipeline enable
// ----------------------------------------------------------------------------
module trv_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  logic [W-1:0] in_data,
  output logic         out_vld,
  output logic [W-1:0] out_data
);
  import trv_pkg::*;

  logic         vld_r [DEPTH];
  logic [W-1:0] dat_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        dat_r[i] <= dat_r[i-1];
      end
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_data = dat_r[DEPTH-1];

endmodule

### hdl/two_ray_vertex_estimate.sv
// ----------------------------------------------------------------------------
// two_ray_vertex_estimate
// vertex estimate from two rays: ray two carried to ray one's z, offsets and
// slope differences divided out, fallback rules applied, result saturated
//
//   channel   ports                                 direction
//   in        in_valid, in_stall, in_ray1_*/ray2_*   two rays in
//   out       out_valid, out_stall, out_vertex_*     one vertex out
//
// one transaction in per cycle while the pipeline is not frozen, one vertex out per transaction
// the data path runs through three bit-per-stage divider chains
// (51, 51 + FRAC_BITS and 81 quotient bits) and eight datapath stages
// synchronous active-low reset clears all valid bits
// out_stall with out_valid high freezes the whole pipeline and raises in_stall
// ----------------------------------------------------------------------------
module two_ray_vertex_estimate #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_ray1_pos_x,
  input  logic signed [31:0] in_ray1_pos_y,
  input  logic signed [31:0] in_ray1_pos_z,
  input  logic signed [17:0] in_ray1_dir_x,
  input  logic signed [17:0] in_ray1_dir_y,
  input  logic signed [17:0] in_ray1_dir_z,
  input  logic signed [31:0] in_ray2_pos_x,
  input  logic signed [31:0] in_ray2_pos_y,
  input  logic signed [31:0] in_ray2_pos_z,
  input  logic signed [17:0] in_ray2_dir_x,
  input  logic signed [17:0] in_ray2_dir_y,
  input  logic signed [17:0] in_ray2_dir_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic signed [31:0] out_vertex_z
);
  import trv_pkg::*;

  localparam int N1 = 33 + DIR_W;
  localparam int D1 = DIR_W;
  localparam int L1 = N1 + 1;
  localparam int DXW = 51;
  localparam int N2 = DXW + FRAC_BITS;
  localparam int D2 = 19 + FRAC_BITS;
  localparam int L2 = N2 + 1;
  localparam int N3 = 81;
  localparam int L3 = N3 + 1;

  localparam int IX_QX2 = 0;
  localparam int IX_QY2 = 1;
  localparam int IX_QF  = 2;
  localparam int IX_S2X = 3;
  localparam int IX_S2Y = 4;
  localparam int IX_S1X = 5;
  localparam int IX_S1Y = 6;
  localparam int NDIV1  = 7;

  typedef struct packed {
    logic signed [POS_W-1:0] x1;
    logic signed [POS_W-1:0] y1;
    logic signed [POS_W-1:0] z1;
    logic signed [POS_W-1:0] x2;
    logic signed [POS_W-1:0] y2;
    logic signed [POS_W-1:0] z2;
    logic signed [DIR_W-1:0] d1x;
    logic signed [DIR_W-1:0] d1y;
    logic signed [DIR_W-1:0] d1z;
    logic                    zok;
    logic                    z1ge;
    logic                    xv;
    logic                    yv;
    logic signed [Q_W-1:0]   vxf;
    logic signed [Q_W-1:0]   vyf;
    logic signed [Q_W-1:0]   dzv;
  } ctx_t;

  function automatic logic [DIR_W-1:0] absd(input logic signed [DIR_W-1:0] d);
    return d[DIR_W-1] ? DIR_W'(-d) : DIR_W'(d);
  endfunction

  function automatic logic [Q_W-1:0] absq(input logic signed [Q_W-1:0] v);
    return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
  endfunction

  function automatic logic signed [Q_W-1:0] sx(input logic signed [POS_W-1:0] v);
    return {{(Q_W-POS_W){v[POS_W-1]}}, v};
  endfunction

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: capture and z difference
  logic                    v1_r;
  logic signed [POS_W-1:0] x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic signed [DIR_W-1:0] d1x_r, d1y_r, d1z_r, d2x_r, d2y_r, d2z_r;
  logic signed [32:0]      dz1_r;
  logic                    z1ge1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= in_ray1_pos_x;
      y1_r    <= in_ray1_pos_y;
      z1_r    <= in_ray1_pos_z;
      x2_r    <= in_ray2_pos_x;
      y2_r    <= in_ray2_pos_y;
      z2_r    <= in_ray2_pos_z;
      d1x_r   <= in_ray1_dir_x;
      d1y_r   <= in_ray1_dir_y;
      d1z_r   <= in_ray1_dir_z;
      d2x_r   <= in_ray2_dir_x;
      d2y_r   <= in_ray2_dir_y;
      d2z_r   <= in_ray2_dir_z;
      dz1_r   <= 33'(in_ray1_pos_z) - 33'(in_ray2_pos_z);
      z1ge1_r <= in_ray1_pos_z >= in_ray2_pos_z;
    end
  end

  // stage 2: magnitudes, products, first divider inputs
  logic        v2_r;
  ctx_t        ctx2_r;
  ctx_t        ctx2_nxt;
  logic [N1-1:0] g1_num_r [NDIV1];
  logic [D1-1:0] g1_den_r [NDIV1];
  logic          g1_neg_r [NDIV1];
  logic [32:0]   mdz;
  logic          sdz;

  assign sdz = dz1_r[32];
  assign mdz = sdz ? 33'(-dz1_r) : 33'(dz1_r);

  always_comb begin
    ctx2_nxt      = '0;
    ctx2_nxt.x1   = x1_r;
    ctx2_nxt.y1   = y1_r;
    ctx2_nxt.z1   = z1_r;
    ctx2_nxt.x2   = x2_r;
    ctx2_nxt.y2   = y2_r;
    ctx2_nxt.z2   = z2_r;
    ctx2_nxt.d1x  = d1x_r;
    ctx2_nxt.d1y  = d1y_r;
    ctx2_nxt.d1z  = d1z_r;
    ctx2_nxt.zok  = (d1z_r != '0) && (d2z_r != '0);
    ctx2_nxt.z1ge = z1ge1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r <= ctx2_nxt;

      g1_num_r[IX_QX2] <= N1'(mdz) * N1'(absd(d2x_r));
      g1_den_r[IX_QX2] <= absd(d2z_r);
      g1_neg_r[IX_QX2] <= sdz ^ d2x_r[DIR_W-1] ^ d2z_r[DIR_W-1];

      g1_num_r[IX_QY2] <= N1'(mdz) * N1'(absd(d2y_r));
      g1_den_r[IX_QY2] <= absd(d2z_r);
      g1_neg_r[IX_QY2] <= sdz ^ d2y_r[DIR_W-1] ^ d2z_r[DIR_W-1];

      g1_num_r[IX_QF]  <= N1'(mdz) * N1'(absd(d1x_r));
      g1_den_r[IX_QF]  <= absd(d1z_r);
      g1_neg_r[IX_QF]  <= !(sdz ^ d1x_r[DIR_W-1] ^ d1z_r[DIR_W-1]);

      g1_num_r[IX_S2X] <= N1'(absd(d2x_r)) << FRAC_BITS;
      g1_den_r[IX_S2X] <= absd(d2z_r);
      g1_neg_r[IX_S2X] <= d2x_r[DIR_W-1] ^ d2z_r[DIR_W-1];

      g1_num_r[IX_S2Y] <= N1'(absd(d2y_r)) << FRAC_BITS;
      g1_den_r[IX_S2Y] <= absd(d2z_r);
      g1_neg_r[IX_S2Y] <= d2y_r[DIR_W-1] ^ d2z_r[DIR_W-1];

      g1_num_r[IX_S1X] <= N1'(absd(d1x_r)) << FRAC_BITS;
      g1_den_r[IX_S1X] <= absd(d1z_r);
      g1_neg_r[IX_S1X] <= d1x_r[DIR_W-1] ^ d1z_r[DIR_W-1];

      g1_num_r[IX_S1Y] <= N1'(absd(d1y_r)) << FRAC_BITS;
      g1_den_r[IX_S1Y] <= absd(d1z_r);
      g1_neg_r[IX_S1Y] <= d1y_r[DIR_W-1] ^ d1z_r[DIR_W-1];
    end
  end

  logic signed [Q_W-1:0] g1_q [NDIV1];

  for (genvar i = 0; i < NDIV1; i++) begin : g_div1
    trv_div #(.N(N1), .D(D1)) u_div (
      .clk (clk),
      .en  (en),
      .num (g1_num_r[i]),
      .den (g1_den_r[i]),
      .neg (g1_neg_r[i]),
      .res (g1_q[i])
    );
  end

  logic vA;
  ctx_t ctxA;

  trv_delay #(.W($bits(ctx_t)), .DEPTH(L1)) u_dly_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v2_r),
    .in_data  (ctx2_r),
    .out_vld  (vA),
    .out_data (ctxA)
  );

  // stage 3: offsets and slope differences
  logic                  v3_r;
  ctx_t                  ctx3_r;
  ctx_t                  ctx3_nxt;
  logic signed [Q_W-1:0] dx_r, dy_r, dsx_r, dsy_r;

  always_comb begin
    ctx3_nxt     = ctxA;
    ctx3_nxt.vxf = sx(ctxA.x1) + g1_q[IX_QF];
    ctx3_nxt.vyf = sx(ctxA.y2) + g1_q[IX_QY2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= vA;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx3_r <= ctx3_nxt;
      dx_r   <= sx(ctxA.x1) - sx(ctxA.x2) - g1_q[IX_QX2];
      dy_r   <= sx(ctxA.y1) - sx(ctxA.y2) - g1_q[IX_QY2];
      dsx_r  <= g1_q[IX_S2X] - g1_q[IX_S1X];
      dsy_r  <= g1_q[IX_S2Y] - g1_q[IX_S1Y];
    end
  end

  // stage 4: view select and z distance divider inputs
  logic          v4_r;
  ctx_t          ctx4_r;
  ctx_t          ctx4_nxt;
  logic [N2-1:0] g2_num_r;
  logic [D2-1:0] g2_den_r;
  logic          g2_neg_r;
  logic          xv3;
  logic signed [Q_W-1:0] nsel, dsel;
  logic [Q_W-1:0] nmag, dmag;

  always_comb begin
    xv3  = dsx_r != '0;
    nsel = xv3 ? dx_r : dy_r;
    dsel = xv3 ? dsx_r : dsy_r;
    nmag = absq(nsel);
    dmag = absq(dsel);
    ctx4_nxt    = ctx3_r;
    ctx4_nxt.xv = xv3;
    ctx4_nxt.yv = dsy_r != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx4_r   <= ctx4_nxt;
      g2_num_r <= N2'(nmag[DXW-1:0]) << FRAC_BITS;
      g2_den_r <= dmag[D2-1:0];
      g2_neg_r <= nsel[Q_W-1] ^ dsel[Q_W-1];
    end
  end

  logic signed [Q_W-1:0] g2_q;

  trv_div #(.N(N2), .D(D2)) u_div2 (
    .clk (clk),
    .en  (en),
    .num (g2_num_r),
    .den (g2_den_r),
    .neg (g2_neg_r),
    .res (g2_q)
  );

  logic vB;
  ctx_t ctxB;

  trv_delay #(.W($bits(ctx_t)), .DEPTH(L2)) u_dly_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v4_r),
    .in_data  (ctx4_r),
    .out_vld  (vB),
    .out_data (ctxB)
  );

  // stage 5: partial products of the z distance with ray one cosines
  logic        v5_r;
  ctx_t        ctx5_r;
  ctx_t        ctx5_nxt;
  logic [49:0] lo_x_r, lo_y_r;
  logic [48:0] hi_x_r, hi_y_r;
  logic        neg_x5_r, neg_y5_r;
  logic [Q_W-1:0] mzv;

  assign mzv = absq(g2_q);

  always_comb begin
    ctx5_nxt     = ctxB;
    ctx5_nxt.dzv = g2_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= vB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx5_r   <= ctx5_nxt;
      lo_x_r   <= 50'(mzv[31:0]) * 50'(absd(ctxB.d1x));
      hi_x_r   <= 49'(mzv[62:32]) * 49'(absd(ctxB.d1x));
      lo_y_r   <= 50'(mzv[31:0]) * 50'(absd(ctxB.d1y));
      hi_y_r   <= 49'(mzv[62:32]) * 49'(absd(ctxB.d1y));
      neg_x5_r <= g2_q[Q_W-1] ^ ctxB.d1x[DIR_W-1] ^ ctxB.d1z[DIR_W-1];
      neg_y5_r <= g2_q[Q_W-1] ^ ctxB.d1y[DIR_W-1] ^ ctxB.d1z[DIR_W-1];
    end
  end

  // stage 6: product sums, last divider inputs
  logic          v6_r;
  ctx_t          ctx6_r;
  logic [N3-1:0] g3x_num_r, g3y_num_r;
  logic [D1-1:0] g3_den_r;
  logic          g3x_neg_r, g3y_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx6_r    <= ctx5_r;
      g3x_num_r <= N3'(lo_x_r) + (N3'(hi_x_r) << 32);
      g3y_num_r <= N3'(lo_y_r) + (N3'(hi_y_r) << 32);
      g3_den_r  <= absd(ctx5_r.d1z);
      g3x_neg_r <= neg_x5_r;
      g3y_neg_r <= neg_y5_r;
    end
  end

  logic signed [Q_W-1:0] g3x_q, g3y_q;

  trv_div #(.N(N3), .D(D1)) u_div3x (
    .clk (clk),
    .en  (en),
    .num (g3x_num_r),
    .den (g3_den_r),
    .neg (g3x_neg_r),
    .res (g3x_q)
  );

  trv_div #(.N(N3), .D(D1)) u_div3y (
    .clk (clk),
    .en  (en),
    .num (g3y_num_r),
    .den (g3_den_r),
    .neg (g3y_neg_r),
    .res (g3y_q)
  );

  logic vC;
  ctx_t ctxC;

  trv_delay #(.W($bits(ctx_t)), .DEPTH(L3)) u_dly_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v6_r),
    .in_data  (ctx6_r),
    .out_vld  (vC),
    .out_data (ctxC)
  );

  // stage 7: single-view vertex
  logic                  v7_r;
  ctx_t                  ctx7_r;
  logic signed [Q_W-1:0] svx_r, svy_r, svz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= vC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx7_r <= ctxC;
      svx_r  <= sx(ctxC.x1) + g3x_q;
      svy_r  <= sx(ctxC.y1) + g3y_q;
      svz_r  <= sx(ctxC.z1) + ctxC.dzv;
    end
  end

  // stage 8: case select and saturation into the output register
  logic                    out_valid_r;
  logic signed [POS_W-1:0] vx_r, vy_r, vz_r;
  logic signed [Q_W-1:0]   fx, fy, fz;

  always_comb begin
    fx = '0;
    fy = '0;
    fz = '0;
    if (!ctx7_r.zok || (!ctx7_r.xv && !ctx7_r.yv)) begin
      fx = '0;
    end else if (ctx7_r.xv != ctx7_r.yv) begin
      fx = svx_r;
      fy = svy_r;
      fz = svz_r;
    end else begin
      fx = ctx7_r.z1ge ? sx(ctx7_r.x1) : sx(ctx7_r.x2);
      fy = ctx7_r.z1ge ? sx(ctx7_r.y1) : sx(ctx7_r.y2);
      fz = ctx7_r.z1ge ? sx(ctx7_r.z1) : sx(ctx7_r.z2);
      if (fx == '0) begin
        fx = ctx7_r.vxf;
        fy = sx(ctx7_r.y2);
        fz = sx(ctx7_r.z2);
      end
      if (fy == '0) begin
        fx = sx(ctx7_r.x1);
        fy = ctx7_r.vyf;
        fz = sx(ctx7_r.z1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r <= sat32(fx);
      vy_r <= sat32(fy);
      vz_r <= sat32(fz);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_vertex_x = vx_r;
  assign out_vertex_y = vy_r;
  assign out_vertex_z = vz_r;

endmodule

### hdl/trv_check.sv
// ----------------------------------------------------------------------------
// trv_check
// port-level checks for the two-ray vertex estimate, bound to the top level
// ----------------------------------------------------------------------------
module trv_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_vertex_x,
  input logic signed [31:0] out_vertex_y,
  input logic signed [31:0] out_vertex_z
);
  import trv_pkg::*;

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertex_x) &&
      $stable(out_vertex_y) && $stable(out_vertex_z))
    else $error("stalled output transaction changed");

  // input backpressure only from a held output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without held output");

  // reset empties the pipeline
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // an accepted input never stalls unless pipeline is held
  a_in_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind two_ray_vertex_estimate trv_check u_trv_check (.*);
